### rtl/bldec_pkg.sv
// ----------------------------------------------------------------------------
// bldec_pkg
// shared types and constants of the bilevel run-length decoder
// ----------------------------------------------------------------------------
package bldec_pkg;

    localparam int CHANNELS = 256;
    localparam int CH_W     = $clog2(CHANNELS);
    localparam int WORD_W   = 16;
    localparam int RUN_W    = 9;
    localparam int BITS_W   = 5;

    localparam logic CMD_DECODE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // per-channel decoder state, as held in the state memory
    typedef struct packed {
        logic [WORD_W-1:0] shift_word;
        logic [BITS_W-1:0] bits_left;
        logic              colour;
        logic [RUN_W-1:0]  run_left;
    } t_state;

    typedef struct packed {
        logic pixel;
        logic word_used;
        logic bad_code;
    } t_result;

    localparam int STATE_W = $bits(t_state);

endpackage

### rtl/bldec_ram.sv
// ----------------------------------------------------------------------------
// bldec_ram
// generic single-write, single-read RAM with registered read data
// ----------------------------------------------------------------------------
module bldec_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/bldec_step.sv
// ----------------------------------------------------------------------------
// bldec_step
// one decode step of a channel: run bookkeeping, flag and run code extraction
// ----------------------------------------------------------------------------
module bldec_step (
    input  bldec_pkg::t_state              i_cur,
    input  logic                           i_cmd,
    input  logic [bldec_pkg::WORD_W-1:0]   i_word,
    output bldec_pkg::t_state              o_nxt,
    output bldec_pkg::t_result             o_res
);
    import bldec_pkg::*;

    logic [2*WORD_W-1:0] w_word_al;
    logic [2*WORD_W-1:0] w_buf;
    logic [2*WORD_W-1:0] w_shifted;
    logic                w_flag;
    logic                w_used;
    logic [3:0]          w_need;
    logic [RUN_W-1:0]    w_code;
    logic [BITS_W:0]     w_bits_tot;

    always_comb begin
        w_word_al = {i_word, {WORD_W{1'b0}}};
        // first bit comes from the word when the shift word is empty
        w_flag = (i_cur.bits_left == '0) ? i_word[WORD_W-1] : i_cur.shift_word[WORD_W-1];
        w_need = w_flag ? 4'(RUN_W + 1) : 4'd1;
        w_used = (i_cur.bits_left < BITS_W'(w_need));
        // remaining bits left-aligned, followed by the fresh word when it is loaded
        if (i_cur.bits_left == '0) begin
            w_buf = w_word_al;
        end else begin
            w_buf = {i_cur.shift_word, {WORD_W{1'b0}}}
                  | (w_used ? (w_word_al >> i_cur.bits_left) : '0);
        end
        w_code     = w_buf[2*WORD_W-2 -: RUN_W];
        w_shifted  = w_buf << w_need;
        w_bits_tot = {1'b0, i_cur.bits_left} + (w_used ? (BITS_W+1)'(WORD_W) : '0)
                   - (BITS_W+1)'(w_need);

        o_nxt = i_cur;
        o_res = '0;
        if (i_cmd == CMD_CLEAR) begin
            o_nxt = '0;
        end else if (i_cur.run_left == '0) begin
            o_nxt.shift_word = w_shifted[2*WORD_W-1 -: WORD_W];
            o_nxt.bits_left  = w_bits_tot[BITS_W-1:0];
            o_nxt.colour     = ~i_cur.colour;
            // a zero long-run code is flagged and decoded as a single pixel
            o_nxt.run_left   = (w_flag && w_code != '0) ? w_code - 1'b1 : '0;
            o_res.pixel      = i_cur.colour;
            o_res.word_used  = w_used;
            o_res.bad_code   = w_flag && (w_code == '0);
        end else begin
            o_nxt.run_left   = i_cur.run_left - 1'b1;
            o_res.pixel      = ~i_cur.colour;
        end
    end

endmodule

### rtl/bilevel_run_length_decoder.sv
// ----------------------------------------------------------------------------
// bilevel_run_length_decoder
// decodes interleaved two-colour run-length streams, one pixel per transaction
// ----------------------------------------------------------------------------
// channel  | direction | tdata                               | tuser
// s_axis   | in        | [7:0] channel, [23:8] next_word     | cmd
// m_axis   | out       | [0] pixel, [1] word_used, [2] bad   | -
//
// one transaction per clock sustained while the output is not stalled; the per-channel
// state ram read is registered in the working stage, the result in the output register
// back-to-back transactions on one channel are served by a write-back bypass
// reset clears the per-channel valid bits at once, no clearing pass needed
// a stalled output holds the working stage, which then holds the input side
// ----------------------------------------------------------------------------
module bilevel_run_length_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // [7:0] channel, [23:8] next_word
    input  logic        i_s_tuser,   // [0] cmd
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata    // [0] pixel, [1] word_used, [2] bad_code
);
    import bldec_pkg::*;

    logic                r_s1_valid;
    logic                r_cmd;
    logic [7:0]          r_ch;
    logic [WORD_W-1:0]   r_word;
    logic                r_inr;

    logic                r_fwd_valid;
    logic [CH_W-1:0]     r_fwd_ch;
    t_state              r_fwd_state;

    logic [CHANNELS-1:0] r_vld;

    logic                r_out_valid;
    t_result             r_out;

    logic                w_s1_ready;
    logic                w_accept;
    logic                w_advance;
    logic                w_fwd_hit;
    logic [STATE_W-1:0]  w_rdata;
    t_state              w_cur;
    t_state              n_state;
    t_result             w_res;

    assign w_s1_ready = !r_s1_valid || !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && w_s1_ready;
    assign w_advance  = r_s1_valid && w_s1_ready;
    assign o_s_tready = w_s1_ready;

    bldec_ram #(
        .WIDTH (STATE_W),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (w_advance && r_inr),
        .i_waddr (r_ch[CH_W-1:0]),
        .i_wdata (n_state),
        .i_re    (w_accept),
        .i_raddr (i_s_tdata[CH_W-1:0]),
        .o_rdata (w_rdata)
    );

    // the previous write lands at the same edge as this read, so bypass it
    assign w_fwd_hit = r_fwd_valid && (r_fwd_ch == r_ch[CH_W-1:0]);

    always_comb begin
        if (w_fwd_hit) begin
            w_cur = r_fwd_state;
        end else if (r_vld[r_ch[CH_W-1:0]]) begin
            w_cur = t_state'(w_rdata);
        end else begin
            w_cur = '0;
        end
    end

    bldec_step u_step (
        .i_cur  (w_cur),
        .i_cmd  (r_cmd),
        .i_word (r_word),
        .o_nxt  (n_state),
        .o_res  (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s1_ready) begin
                r_s1_valid  <= i_s_tvalid;
                r_fwd_valid <= r_s1_valid && r_inr;
            end
            if (w_advance && r_inr) begin
                r_vld[r_ch[CH_W-1:0]] <= 1'b1;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd  <= i_s_tuser;
            r_ch   <= i_s_tdata[7:0];
            r_word <= i_s_tdata[23:8];
            r_inr  <= (int'(i_s_tdata[7:0]) < CHANNELS);
        end
        if (w_s1_ready) begin
            r_fwd_ch    <= r_ch[CH_W-1:0];
            r_fwd_state <= n_state;
        end
        if (w_advance) begin
            r_out <= r_inr ? w_res : '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'b0, r_out.bad_code, r_out.word_used, r_out.pixel};

`ifndef SYNTH
    a_fwd_entry_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && w_fwd_hit) |-> r_vld[r_ch[CH_W-1:0]])
        else $error("bypass hit on a channel never written");

    a_bits_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |-> (n_state.bits_left <= BITS_W'(WORD_W)))
        else $error("bits left beyond one word");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s1_ready) |=> (r_s1_valid && $stable(r_ch) && $stable(r_word)))
        else $error("working stage changed while stalled");

    a_used_needs_new_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_res.word_used) |-> (r_cmd == CMD_DECODE && w_cur.run_left == '0))
        else $error("word consumed without starting a run");
`endif

endmodule
